@@ rtl/core/sfb_pkg.sv @@
package sfb_pkg;

    // coordinate counters and the scan limit
    localparam int COORD_W = 12;
    // image, screen and render dimensions
    localparam int DIM_W = 13;
    // draw origin
    localparam int ORG_W = 12;
    // pixel indices
    localparam int IDX_W = 24;
    // coordinate times dimension (divider dividend)
    localparam int PROD_W = COORD_W + DIM_W;
    // dimension times dimension (index products)
    localparam int PIX_W = 2 * DIM_W;
    // divider step counter
    localparam int DIV_CNT_W = $clog2(DIM_W + 1);

    // configuration port
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = DIM_W;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REQUEST_WIDTH  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_REQUEST_HEIGHT = 3'd7;

    localparam logic [DIM_W-1:0] SCREEN_WIDTH_RST  = 13'd640;
    localparam logic [DIM_W-1:0] SCREEN_HEIGHT_RST = 13'd480;

    // clipped size saturates here so the scan counters never wrap
    localparam logic [DIM_W-1:0] COORD_LIMIT = DIM_W'(2 ** COORD_W);

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic eval;
        logic div_start;
        logic sel_y;
        logic capture_qx;
        logic capture_qy;
        logic mul;
        logic emit;
    } sfb_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic pixel;
        logic div_busy;
        logic out_free;
    } sfb_status_t;

endpackage

@@ rtl/core/sfb_divider.sv @@
module sfb_divider
    import sfb_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  logic [DIM_W-1:0]  divisor,
    output logic              busy,
    output logic [DIM_W-1:0]  quotient
);

    // restoring divider, one quotient bit a cycle; the caller guarantees
    // the quotient fits in DIM_W bits, so the upper dividend bits start
    // out as the partial remainder
    logic [DIM_W-1:0]     rem_reg;
    logic [DIM_W-1:0]     quo_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic [DIM_W-1:0]     div_reg;

    logic [DIM_W:0]       trial;
    logic                 ge;
    logic [DIM_W:0]       diff;

    always_comb begin
        trial = {rem_reg, quo_reg[DIM_W-1]};
        ge    = trial >= {1'b0, div_reg};
        diff  = trial - {1'b0, div_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(DIM_W);
        end else if (busy_reg) begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= cnt_reg != DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= DIM_W'(dividend[PROD_W-1:DIM_W]);
            quo_reg <= dividend[DIM_W-1:0];
            div_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
            quo_reg <= {quo_reg[DIM_W-2:0], ge};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/core/sfb_datapath.sv @@
module sfb_datapath
    import sfb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_start_req,
    input  logic                  m_ready,
    input  sfb_cmd_t              cmd,
    output sfb_status_t           status,
    output logic                  m_valid,
    output logic                  m_valid_res,
    output logic                  m_last,
    output logic [IDX_W-1:0]      m_source_index,
    output logic [IDX_W-1:0]      m_dest_index
);

    // configuration
    logic [DIM_W-1:0] screen_width_reg, screen_height_reg;
    logic [DIM_W-1:0] image_width_reg, image_height_reg;
    logic [ORG_W-1:0] origin_x_reg, origin_y_reg;
    logic [DIM_W-1:0] request_width_reg, request_height_reg;

    // scan state
    logic               start_reg;
    logic               drawing_reg;
    logic [COORD_W-1:0] scan_col_reg, scan_row_reg;
    logic               pix_reg, last_reg;

    // per-pixel arithmetic
    logic [DIM_W-1:0] qx_reg, qy_reg, sx_reg, dst_off_reg;
    logic [PIX_W-1:0] src_prod_reg, dst_prod_reg;

    // result beat
    logic             m_valid_reg, m_valid_res_reg, m_last_reg;
    logic [IDX_W-1:0] m_source_index_reg, m_dest_index_reg;

    // geometry
    logic             ok;
    logic [DIM_W-1:0] rw, rh, w_clip, h_clip, dw, dh;
    logic [DIM_W:0]   x_end, y_end;

    // next position
    logic [DIM_W-1:0] col_inc, col_n, row_n, col_sel, row_sel;
    logic             wraps, off_end, pix, pix_last;

    // divider
    logic [PROD_W-1:0] div_dividend;
    logic [DIM_W-1:0]  div_divisor, div_quotient;
    logic              div_busy;

    // index arithmetic
    logic [DIM_W-1:0] sy, dst_row;

    always_comb begin
        ok = (image_width_reg != '0) && (image_height_reg != '0) &&
             (DIM_W'(origin_x_reg) < screen_width_reg) &&
             (DIM_W'(origin_y_reg) < screen_height_reg);
        rw = (request_width_reg != '0) ? request_width_reg : image_width_reg;
        rh = (request_height_reg != '0) ? request_height_reg : image_height_reg;
        x_end = (DIM_W+1)'(origin_x_reg) + (DIM_W+1)'(rw);
        y_end = (DIM_W+1)'(origin_y_reg) + (DIM_W+1)'(rh);
        w_clip = (x_end > {1'b0, screen_width_reg}) ?
                 screen_width_reg - DIM_W'(origin_x_reg) : rw;
        h_clip = (y_end > {1'b0, screen_height_reg}) ?
                 screen_height_reg - DIM_W'(origin_y_reg) : rh;
        dw = (w_clip > COORD_LIMIT) ? COORD_LIMIT : w_clip;
        dh = (h_clip > COORD_LIMIT) ? COORD_LIMIT : h_clip;
    end

    always_comb begin
        col_inc = DIM_W'(scan_col_reg) + 1'b1;
        wraps   = col_inc >= dw;
        col_n   = wraps ? '0 : col_inc;
        row_n   = wraps ? DIM_W'(scan_row_reg) + 1'b1 : DIM_W'(scan_row_reg);
        off_end = row_n >= dh;
        col_sel = start_reg ? '0 : col_n;
        row_sel = start_reg ? '0 : row_n;
        pix     = start_reg ? ok : (drawing_reg && ok && !off_end);
        pix_last = (col_sel == dw - 1'b1) && (row_sel == dh - 1'b1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_width_reg   <= SCREEN_WIDTH_RST;
            screen_height_reg  <= SCREEN_HEIGHT_RST;
            image_width_reg    <= '0;
            image_height_reg   <= '0;
            origin_x_reg       <= '0;
            origin_y_reg       <= '0;
            request_width_reg  <= '0;
            request_height_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SCREEN_WIDTH:   screen_width_reg   <= cfg_data;
                REG_SCREEN_HEIGHT:  screen_height_reg  <= cfg_data;
                REG_IMAGE_WIDTH:    image_width_reg    <= cfg_data;
                REG_IMAGE_HEIGHT:   image_height_reg   <= cfg_data;
                REG_ORIGIN_X:       origin_x_reg       <= cfg_data[ORG_W-1:0];
                REG_ORIGIN_Y:       origin_y_reg       <= cfg_data[ORG_W-1:0];
                REG_REQUEST_WIDTH:  request_width_reg  <= cfg_data;
                REG_REQUEST_HEIGHT: request_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // scan state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drawing_reg  <= 1'b0;
            scan_col_reg <= '0;
            scan_row_reg <= '0;
            pix_reg      <= 1'b0;
            last_reg     <= 1'b0;
            start_reg    <= 1'b0;
        end else begin
            if (cmd.accept) begin
                start_reg <= s_start_req;
            end
            if (cmd.eval) begin
                pix_reg <= pix;
                if (pix) begin
                    scan_col_reg <= col_sel[COORD_W-1:0];
                    scan_row_reg <= row_sel[COORD_W-1:0];
                    last_reg     <= pix_last;
                    drawing_reg  <= !pix_last;
                end else begin
                    // reject or abort ends the draw; idle advance leaves it idle
                    last_reg    <= start_reg || drawing_reg;
                    drawing_reg <= 1'b0;
                end
            end
        end
    end

    // the column or the row product, chosen by sel_y, feeds the shared divider
    always_comb begin
        div_dividend = cmd.sel_y ?
                       PROD_W'(scan_row_reg) * PROD_W'(image_height_reg) :
                       PROD_W'(scan_col_reg) * PROD_W'(image_width_reg);
        div_divisor  = cmd.sel_y ? rh : rw;
    end

    sfb_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    always_comb begin
        sy      = image_height_reg - 1'b1 - qy_reg;
        dst_row = DIM_W'(origin_y_reg) + DIM_W'(scan_row_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture_qx) begin
            qx_reg <= div_quotient;
        end
        if (cmd.capture_qy) begin
            qy_reg <= div_quotient;
        end
        if (cmd.mul) begin
            sx_reg       <= image_width_reg - 1'b1 - qx_reg;
            src_prod_reg <= PIX_W'(sy) * PIX_W'(image_width_reg);
            dst_prod_reg <= PIX_W'(dst_row) * PIX_W'(screen_width_reg);
            dst_off_reg  <= DIM_W'(origin_x_reg) + DIM_W'(scan_col_reg);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_valid_res_reg <= pix_reg;
            m_last_reg      <= last_reg;
            if (pix_reg) begin
                m_source_index_reg <= src_prod_reg[IDX_W-1:0] + IDX_W'(sx_reg);
                m_dest_index_reg   <= dst_prod_reg[IDX_W-1:0] + IDX_W'(dst_off_reg);
            end else begin
                m_source_index_reg <= '0;
                m_dest_index_reg   <= '0;
            end
        end
    end

    assign status.pixel    = pix;
    assign status.div_busy = div_busy;
    assign status.out_free = !m_valid_reg || m_ready;

    assign m_valid        = m_valid_reg;
    assign m_valid_res    = m_valid_res_reg;
    assign m_last         = m_last_reg;
    assign m_source_index = m_source_index_reg;
    assign m_dest_index   = m_dest_index_reg;

endmodule

@@ rtl/core/sfb_ctrl.sv @@
module sfb_ctrl
    import sfb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  sfb_status_t status,
    output sfb_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EVAL  = 3'd1;
    localparam logic [2:0] ST_PRODX = 3'd2;
    localparam logic [2:0] ST_DIVX  = 3'd3;
    localparam logic [2:0] ST_PRODY = 3'd4;
    localparam logic [2:0] ST_DIVY  = 3'd5;
    localparam logic [2:0] ST_MUL   = 3'd6;
    localparam logic [2:0] ST_EMIT  = 3'd7;

    logic [2:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = status.pixel ? ST_PRODX : ST_EMIT;
            end
            ST_PRODX: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIVX;
            end
            ST_DIVX: begin
                if (!status.div_busy) begin
                    cmd.capture_qx = 1'b1;
                    state_next     = ST_PRODY;
                end
            end
            ST_PRODY: begin
                cmd.div_start = 1'b1;
                cmd.sel_y     = 1'b1;
                state_next    = ST_DIVY;
            end
            ST_DIVY: begin
                if (!status.div_busy) begin
                    cmd.capture_qy = 1'b1;
                    state_next     = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/core/scaled_flipped_blit_address_gen.sv @@
// nearest-neighbor scaled blit address generator. each input beat is a tick:
// start_req=1 restarts the scan at the top-left pixel of the screen-clipped
// rectangle, start_req=0 advances one pixel along the row-major scan. every
// tick returns exactly one result beat: a source/destination index pair for
// the pixel (valid_res=1), with last=1 on the final pixel, or a beat with
// valid_res=0 and zero indices when the draw is rejected or aborts (last=1)
// or when the block is ticked while idle (last=0). the source is mirrored in
// both axes. geometry comes from the configuration registers, which may be
// written only while no tick is in flight. one tick is in flight at a time:
// a pixel tick uses the shared one-bit-per-cycle divider to scale the column
// and then the row, then the index multiply; a tick that yields no pixel goes
// from evaluation straight to its result beat. the next tick is accepted while
// an earlier result beat still waits in the output register.
module scaled_flipped_blit_address_gen
    import sfb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    // tick input
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_start_req,

    // address pair output
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_valid_res,
    output logic                  m_last,
    output logic [IDX_W-1:0]      m_source_index,
    output logic [IDX_W-1:0]      m_dest_index
);

    sfb_cmd_t    cmd;
    sfb_status_t status;

    // sequencer: accept, evaluate geometry, two divides, index multiply, emit
    sfb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // config registers, scan counters, divider, index math, output register
    sfb_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_start_req    (s_start_req),
        .m_ready        (m_ready),
        .cmd            (cmd),
        .status         (status),
        .m_valid        (m_valid),
        .m_valid_res    (m_valid_res),
        .m_last         (m_last),
        .m_source_index (m_source_index),
        .m_dest_index   (m_dest_index)
    );

    // a beat that names no pixel carries zero indices
    a_zero_idx_on_no_pixel: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_valid_res) |-> (m_source_index == '0 && m_dest_index == '0)
    ) else $error("non-pixel beat with nonzero index");

    // only one tick in flight: accept closes the input until the result is queued
    a_one_in_flight: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready
    ) else $error("input accepted twice back to back");

    // the divider is never restarted while it is still iterating
    a_div_not_restarted: assert property (
        @(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> !status.div_busy
    ) else $error("divider started while busy");

    // a result is queued only into a free output register
    a_emit_into_free_slot: assert property (
        @(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid || m_ready)
    ) else $error("result overwrote a pending beat");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import sfb_pkg::*;

    // run control
    localparam int HALF_PERIOD    = 4;
    localparam int SETTLE_CYCLES  = 4;     // idle cycles before a register write
    localparam int TAIL_CYCLES    = 40;    // one pixel tick plus margin
    localparam int WATCHDOG_LIMIT = 4000;  // cycles without any beat or write
    localparam int TICK_TARGET    = 1000;
    localparam int DRAW_CAP       = 40;    // longest draw queued on a large geometry

    // what the driver does next
    typedef enum logic [1:0] {
        OP_TICK,
        OP_WRITE,
        OP_DRAIN,
        OP_MODE
    } drive_kind_t;

    typedef struct {
        drive_kind_t          kind;
        logic                 start;
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_DATA_W-1:0] data;
        int                   idle_pct;
        int                   stall_pct;
    } drive_op_t;

    // one address pair beat
    typedef struct packed {
        logic             valid_res;
        logic             last;
        logic [IDX_W-1:0] source_index;
        logic [IDX_W-1:0] dest_index;
    } addr_pair_t;

    // dut ports, the inputs known from time zero
    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = REG_SCREEN_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic                  s_start_req = 1'b0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic                  m_valid_res;
    logic                  m_last;
    logic [IDX_W-1:0]      m_source_index;
    logic [IDX_W-1:0]      m_dest_index;

    // stimulus and scoreboard
    drive_op_t  tick_plan[$];
    addr_pair_t pairs_due[$];
    int         errors      = 0;
    bit         timed_out   = 1'b0;
    bit         tick_taken  = 1'b0;
    int         idle_pct    = 0;
    int         stall_pct   = 0;
    int         quiet       = 0;
    int         stall_count = 0;
    int         ticks_queued = 0;

    // register values as the generator plans them, indexed by register code
    int unsigned plan_regs[8];

    // shadow of the block's registers and scan state
    logic [DIM_W-1:0]   scr_w = SCREEN_WIDTH_RST;
    logic [DIM_W-1:0]   scr_h = SCREEN_HEIGHT_RST;
    logic [DIM_W-1:0]   img_w = '0;
    logic [DIM_W-1:0]   img_h = '0;
    logic [ORG_W-1:0]   org_x = '0;
    logic [ORG_W-1:0]   org_y = '0;
    logic [DIM_W-1:0]   req_w = '0;
    logic [DIM_W-1:0]   req_h = '0;
    logic [COORD_W-1:0] scan_col = '0;
    logic [COORD_W-1:0] scan_row = '0;
    logic               drawing  = 1'b0;

    scaled_flipped_blit_address_gen i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_start_req    (s_start_req),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_valid_res    (m_valid_res),
        .m_last         (m_last),
        .m_source_index (m_source_index),
        .m_dest_index   (m_dest_index)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // clipped draw extent and render size; ok low means the draw is rejected
    function automatic void clip_extent(
        input  int unsigned sw, sh, iw, ih, ox, oy, rqw, rqh,
        output bit ok,
        output int unsigned dw, dh, rw, rh
    );
        ok = (iw != 0) && (ih != 0) && (ox < sw) && (oy < sh);
        dw = 0;
        dh = 0;
        rw = 1;
        rh = 1;
        if (ok) begin
            rw = (rqw != 0) ? rqw : iw;
            rh = (rqh != 0) ? rqh : ih;
            dw = (ox + rw > sw) ? sw - ox : rw;
            dh = (oy + rh > sh) ? sh - oy : rh;
            // the clipped extent saturates at the coordinate range
            if (dw > int'(COORD_LIMIT)) dw = COORD_LIMIT;
            if (dh > int'(COORD_LIMIT)) dh = COORD_LIMIT;
        end
    endfunction

    // steps the scan by one tick and returns the address pair it yields
    function automatic addr_pair_t advance_scan(input logic start);
        addr_pair_t        r;
        bit                ok;
        int unsigned       dw, dh, rw, rh, col, row, sx, sy;
        longint unsigned   q, idx;
        r = '0;
        clip_extent(scr_w, scr_h, img_w, img_h, org_x, org_y, req_w, req_h,
                    ok, dw, dh, rw, rh);
        if (start) begin
            // rejected start ends any draw in progress
            if (!ok) begin
                drawing = 1'b0;
                r.last  = 1'b1;
                return r;
            end
            col = 0;
            row = 0;
        end else begin
            // advance while idle does nothing
            if (!drawing) return r;
            // geometry became invalid under a running draw
            if (!ok) begin
                drawing = 1'b0;
                r.last  = 1'b1;
                return r;
            end
            col = scan_col + 1;
            row = scan_row;
            if (col >= dw) begin
                col = 0;
                row++;
            end
            // next position fell outside a shrunken rectangle
            if (row >= dh) begin
                drawing = 1'b0;
                r.last  = 1'b1;
                return r;
            end
        end
        r.last    = (col == dw - 1) && (row == dh - 1);
        drawing   = !r.last;
        scan_col  = COORD_W'(col);
        scan_row  = COORD_W'(row);
        // mirrored nearest-neighbor source coordinates
        q  = col;
        q  = q * img_w / rw;
        sx = img_w - 1 - int'(q);
        q  = row;
        q  = q * img_h / rh;
        sy = img_h - 1 - int'(q);
        r.valid_res = 1'b1;
        idx = sy;
        r.source_index = IDX_W'(idx * img_w + sx);
        idx = org_y + row;
        r.dest_index   = IDX_W'(idx * scr_w + org_x + col);
        return r;
    endfunction

    task automatic apply_write(input logic [CFG_IDX_W-1:0] code,
                               input logic [CFG_DATA_W-1:0] value);
        case (code)
            REG_SCREEN_WIDTH:   scr_w = value;
            REG_SCREEN_HEIGHT:  scr_h = value;
            REG_IMAGE_WIDTH:    img_w = value;
            REG_IMAGE_HEIGHT:   img_h = value;
            REG_ORIGIN_X:       org_x = value[ORG_W-1:0];
            REG_ORIGIN_Y:       org_y = value[ORG_W-1:0];
            REG_REQUEST_WIDTH:  req_w = value;
            REG_REQUEST_HEIGHT: req_h = value;
            default: ;
        endcase
    endtask

    task automatic check_field(input string what, input logic [IDX_W-1:0] want,
                               input logic [IDX_W-1:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
        end
    endtask

    // ---------------------------------------------------------------
    // stimulus queueing
    // ---------------------------------------------------------------

    task automatic queue_tick(input logic start);
        drive_op_t op;
        op = '{kind: OP_TICK, start: start, index: REG_SCREEN_WIDTH, data: '0,
               idle_pct: 0, stall_pct: 0};
        tick_plan.push_back(op);
        ticks_queued++;
    endtask

    task automatic queue_write(input logic [CFG_IDX_W-1:0] code, input int unsigned value);
        drive_op_t op;
        op = '{kind: OP_WRITE, start: 1'b0, index: code, data: CFG_DATA_W'(value),
               idle_pct: 0, stall_pct: 0};
        tick_plan.push_back(op);
        plan_regs[code] = value;
    endtask

    task automatic queue_mode(input int idle, input int stall);
        drive_op_t op;
        op = '{kind: OP_MODE, start: 1'b0, index: REG_SCREEN_WIDTH, data: '0,
               idle_pct: idle, stall_pct: stall};
        tick_plan.push_back(op);
    endtask

    // sender holds off until every pending pair has come back
    task automatic queue_drain();
        drive_op_t op;
        op = '{kind: OP_DRAIN, start: 1'b0, index: REG_SCREEN_WIDTH, data: '0,
               idle_pct: 0, stall_pct: 0};
        tick_plan.push_back(op);
    endtask

    task automatic queue_geometry(input int unsigned sw, sh, iw, ih, ox, oy, rqw, rqh);
        queue_write(REG_SCREEN_WIDTH, sw);
        queue_write(REG_SCREEN_HEIGHT, sh);
        queue_write(REG_IMAGE_WIDTH, iw);
        queue_write(REG_IMAGE_HEIGHT, ih);
        queue_write(REG_ORIGIN_X, ox);
        queue_write(REG_ORIGIN_Y, oy);
        queue_write(REG_REQUEST_WIDTH, rqw);
        queue_write(REG_REQUEST_HEIGHT, rqh);
    endtask

    // pixels in a full draw under the planned registers, zero when rejected
    function automatic longint unsigned planned_pixels();
        bit          ok;
        int unsigned dw, dh, rw, rh;
        longint unsigned n;
        clip_extent(plan_regs[REG_SCREEN_WIDTH], plan_regs[REG_SCREEN_HEIGHT],
                    plan_regs[REG_IMAGE_WIDTH], plan_regs[REG_IMAGE_HEIGHT],
                    plan_regs[REG_ORIGIN_X], plan_regs[REG_ORIGIN_Y],
                    plan_regs[REG_REQUEST_WIDTH], plan_regs[REG_REQUEST_HEIGHT],
                    ok, dw, dh, rw, rh);
        n = dw;
        return ok ? n * dh : 0;
    endfunction

    // full-range dimension with the maximum favored
    function automatic int unsigned pick_dim(input int unsigned hi);
        return ($urandom_range(0, 3) == 0) ? hi : $urandom_range(1, hi);
    endfunction

    task automatic queue_random_geometry();
        bit          wide;
        int unsigned sw, sh, iw, ih, ox, oy, rqw, rqh;
        // mostly small frames so whole draws fit, sometimes the full range
        wide = ($urandom_range(0, 7) == 0);
        sw   = wide ? pick_dim(4096) : $urandom_range(1, 16);
        sh   = wide ? pick_dim(4096) : $urandom_range(1, 16);
        iw   = wide ? pick_dim(4096) : (($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 8));
        ih   = wide ? pick_dim(4096) : (($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 8));
        // origin mostly on screen, now and then anywhere
        ox   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, sw - 1);
        oy   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, sh - 1);
        rqw  = ($urandom_range(0, 3) == 0) ? 0 : (wide ? pick_dim(4096) : $urandom_range(1, 10));
        rqh  = ($urandom_range(0, 3) == 0) ? 0 : (wide ? pick_dim(4096) : $urandom_range(1, 10));
        queue_geometry(sw, sh, iw, ih, ox, oy, rqw, rqh);
    endtask

    // one register rewritten under a draw that may still be running
    task automatic queue_random_write();
        case ($urandom_range(0, 7))
            0: queue_write(REG_SCREEN_WIDTH, $urandom_range(1, 16));
            1: queue_write(REG_SCREEN_HEIGHT, $urandom_range(1, 16));
            2: queue_write(REG_IMAGE_WIDTH, $urandom_range(0, 8));
            3: queue_write(REG_IMAGE_HEIGHT, $urandom_range(0, 8));
            4: queue_write(REG_ORIGIN_X, $urandom_range(0, 16));
            5: queue_write(REG_ORIGIN_Y, $urandom_range(0, 16));
            6: queue_write(REG_REQUEST_WIDTH, $urandom_range(0, 10));
            default: queue_write(REG_REQUEST_HEIGHT, $urandom_range(0, 10));
        endcase
    endtask

    task automatic queue_random_draw();
        longint unsigned n, full;
        int              pick;
        n    = planned_pixels();
        full = (n > DRAW_CAP) ? DRAW_CAP : n;
        pick = $urandom_range(0, 19);
        if (pick < 14) begin
            // well-formed draw, sometimes with advances past its end
            queue_tick(1'b1);
            repeat ((full == 0) ? 0 : full - 1) queue_tick(1'b0);
            if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 2)) queue_tick(1'b0);
        end else if (pick < 16) begin
            // stray advances
            repeat ($urandom_range(1, 3)) queue_tick(1'b0);
        end else if (pick < 18) begin
            // partial draw, the next start cuts it off
            queue_tick(1'b1);
            repeat ($urandom_range(0, full)) queue_tick(1'b0);
        end else if (pick < 19) begin
            // registers change under a running draw
            queue_tick(1'b1);
            repeat ($urandom_range(0, full)) queue_tick(1'b0);
            queue_random_write();
            repeat ($urandom_range(1, 4)) queue_tick(1'b0);
        end else begin
            queue_drain();
            queue_tick(1'b1);
        end
    endtask

    // ---------------------------------------------------------------
    // driver: payload and handshakes change on the falling edge
    // ---------------------------------------------------------------

    always @(negedge aclk) begin : driver
        drive_op_t             op;
        logic                  nv, ns, nwe;
        logic [CFG_IDX_W-1:0]  ni;
        logic [CFG_DATA_W-1:0] nd;
        nv  = s_valid;
        ns  = s_start_req;
        nwe = 1'b0;
        ni  = cfg_index;
        nd  = cfg_data;
        // beat went through on the last rising edge
        if (tick_taken) begin
            nv         = 1'b0;
            tick_taken = 1'b0;
        end
        // idle time with nothing outstanding, gates register writes
        if (pairs_due.size() != 0) quiet = 0;
        else if (quiet < SETTLE_CYCLES) quiet++;
        if (aresetn && !nv && tick_plan.size() != 0) begin
            op = tick_plan[0];
            case (op.kind)
                OP_TICK: begin
                    if ($urandom_range(99) >= idle_pct) begin
                        nv = 1'b1;
                        ns = op.start;
                        void'(tick_plan.pop_front());
                    end
                end
                OP_WRITE: begin
                    if (quiet >= SETTLE_CYCLES) begin
                        nwe = 1'b1;
                        ni  = op.index;
                        nd  = op.data;
                        void'(tick_plan.pop_front());
                    end
                end
                OP_DRAIN: begin
                    if (pairs_due.size() == 0) void'(tick_plan.pop_front());
                end
                default: begin
                    idle_pct  = op.idle_pct;
                    stall_pct = op.stall_pct;
                    void'(tick_plan.pop_front());
                end
            endcase
        end
        s_valid     <= nv;
        s_start_req <= ns;
        cfg_we      <= nwe;
        cfg_index   <= ni;
        cfg_data    <= nd;
        m_ready     <= ($urandom_range(99) >= stall_pct);
    end

    // ---------------------------------------------------------------
    // monitor: predicts on accepted ticks, checks accepted pairs
    // ---------------------------------------------------------------

    always @(posedge aclk) begin : monitor
        addr_pair_t want;
        bit         busy;
        busy = 1'b0;
        if (aresetn && !timed_out) begin
            if (cfg_we) begin
                apply_write(cfg_index, cfg_data);
                busy = 1'b1;
            end
            if (s_valid && s_ready) begin
                pairs_due.push_back(advance_scan(s_start_req));
                tick_taken = 1'b1;
                busy = 1'b1;
            end
            if (m_valid && m_ready) begin
                busy = 1'b1;
                if (pairs_due.size() == 0) begin
                    errors++;
                    $display("%0t: result beat with no tick outstanding, got %0b/%0b/0x%0h/0x%0h",
                             $time, m_valid_res, m_last, m_source_index, m_dest_index);
                end else begin
                    want = pairs_due.pop_front();
                    check_field("valid_res", IDX_W'(want.valid_res), IDX_W'(m_valid_res));
                    check_field("last", IDX_W'(want.last), IDX_W'(m_last));
                    check_field("source_index", want.source_index, m_source_index);
                    check_field("dest_index", want.dest_index, m_dest_index);
                end
            end
            // watchdog on beats and writes
            stall_count = busy ? 0 : stall_count + 1;
            if (stall_count >= WATCHDOG_LIMIT) begin
                errors++;
                timed_out = 1'b1;
                $display("%0t: no progress for %0d cycles, %0d pairs outstanding",
                         $time, WATCHDOG_LIMIT, pairs_due.size());
            end
        end
    end

    // ---------------------------------------------------------------
    // sequence and end of run
    // ---------------------------------------------------------------

    initial begin
        plan_regs[REG_SCREEN_WIDTH]   = SCREEN_WIDTH_RST;
        plan_regs[REG_SCREEN_HEIGHT]  = SCREEN_HEIGHT_RST;
        plan_regs[REG_IMAGE_WIDTH]    = 0;
        plan_regs[REG_IMAGE_HEIGHT]   = 0;
        plan_regs[REG_ORIGIN_X]       = 0;
        plan_regs[REG_ORIGIN_Y]       = 0;
        plan_regs[REG_REQUEST_WIDTH]  = 0;
        plan_regs[REG_REQUEST_HEIGHT] = 0;

        // directed part, no idling
        queue_mode(0, 0);
        // reset state has no image: start rejected, advance while idle
        queue_tick(1'b1);
        queue_tick(1'b0);
        // native size, clipped at the right edge to 2x2, one advance past the end
        queue_geometry(16, 12, 3, 2, 14, 10, 0, 0);
        queue_tick(1'b1);
        repeat (4) queue_tick(1'b0);
        // upscaled width, then the render width shrinks under the draw and it aborts
        queue_geometry(16, 12, 2, 2, 0, 0, 5, 1);
        queue_tick(1'b1);
        repeat (2) queue_tick(1'b0);
        queue_write(REG_REQUEST_WIDTH, 1);
        queue_tick(1'b0);
        // origin on the right edge, on the bottom edge, and a missing image height
        queue_write(REG_ORIGIN_X, 16);
        queue_tick(1'b1);
        queue_write(REG_ORIGIN_X, 0);
        queue_write(REG_ORIGIN_Y, 12);
        queue_tick(1'b1);
        queue_write(REG_ORIGIN_Y, 0);
        queue_write(REG_IMAGE_HEIGHT, 0);
        queue_tick(1'b1);
        // full-range registers: single corner pixel
        queue_geometry(4096, 4096, 4096, 4096, 4095, 4095, 4096, 4096);
        queue_tick(1'b1);
        // top-left corner, restart while drawing
        queue_write(REG_ORIGIN_X, 0);
        queue_write(REG_ORIGIN_Y, 0);
        queue_tick(1'b1);
        repeat (2) queue_tick(1'b0);
        queue_tick(1'b1);
        // whole image squeezed onto one pixel
        queue_write(REG_REQUEST_WIDTH, 1);
        queue_write(REG_REQUEST_HEIGHT, 1);
        queue_tick(1'b1);
        queue_drain();
        // image removed under a running draw
        queue_geometry(8, 8, 4, 4, 2, 2, 0, 0);
        queue_tick(1'b1);
        queue_tick(1'b0);
        queue_write(REG_IMAGE_WIDTH, 0);
        queue_tick(1'b0);

        // random part, idling mode changes every phase
        for (int phase = 0; ticks_queued < TICK_TARGET; phase++) begin
            int phase_end;
            phase_end = ticks_queued + TICK_TARGET / 8;
            case (phase % 4)
                0: queue_mode(0, 0);
                1: queue_mode(65, 0);
                2: queue_mode(0, 65);
                default: queue_mode(26, 26);
            endcase
            queue_random_geometry();
            while (ticks_queued < phase_end) begin
                if ($urandom_range(0, 2) == 0) queue_random_geometry();
                queue_random_draw();
            end
        end

        // hold reset, then release it on a falling edge
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        while (!timed_out && (tick_plan.size() != 0 || s_valid || pairs_due.size() != 0))
            @(posedge aclk);
        if (!timed_out) repeat (TAIL_CYCLES) @(posedge aclk);
        if (pairs_due.size() != 0) begin
            errors++;
            $display("%0t: %0d pairs never arrived", $time, pairs_due.size());
        end

        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/sfb_pkg.sv
rtl/core/sfb_divider.sv
rtl/core/sfb_datapath.sv
rtl/core/sfb_ctrl.sv
rtl/core/scaled_flipped_blit_address_gen.sv
tb/tb.sv
